// ----- rtl/sjfq_pkg.sv -----
package sjfq_pkg;

    // Field widths
    localparam int KEY_W    = 16;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    // Default queue depth
    localparam int QUEUE_DEPTH_DEF = 8;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One queued job
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_entry;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

// ----- rtl/shortest_job_first_queue_unit.sv -----
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-----------------------------------
// input    | in        | i_in_valid / o_in_ready | i_op, i_burst_time, i_process_id
// output   | out       | o_out_valid/ i_out_ready| o_popped_id, o_popped_time,
//          |           |                         | o_status, o_occupancy
//
// The result of each accepted word appears in the output register
// on the next cycle. The row of cells compares every slot with the new key
// in parallel, so one word per cycle is sustained while the output is drained.
// A stalled output blocks input only while the output register is still full.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
module shortest_job_first_queue_unit #(
    parameter int QUEUE_DEPTH = sjfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [sjfq_pkg::KEY_W-1:0]    i_burst_time,
    input  logic [sjfq_pkg::ID_W-1:0]     i_process_id,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sjfq_pkg::ID_W-1:0]     o_popped_id,
    output logic [sjfq_pkg::KEY_W-1:0]    o_popped_time,
    output logic [sjfq_pkg::STATUS_W-1:0] o_status,
    output logic [sjfq_pkg::OCC_W-1:0]    o_occupancy
);
    import sjfq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic [ID_W-1:0]     r_popped_id;
    logic [KEY_W-1:0]    r_popped_time;
    logic [STATUS_W-1:0] r_status;
    logic [OCC_W-1:0]    r_occupancy;

    logic                accept;
    logic                full;
    logic                empty;
    logic [STATUS_W-1:0] status;
    logic [CNT_W+OCC_W-1:0] occ_ext;
    t_cell_ctl           ctl;
    t_entry              w_entry [QUEUE_DEPTH];
    logic                w_keep  [QUEUE_DEPTH];

    // Input side handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty      = (r_count == '0);

    // Broadcast control to the row
    always_comb begin
        ctl.ins           = accept && (i_op == OP_INSERT) && !full;
        ctl.pop           = accept && (i_op == OP_POP) && !empty;
        ctl.new_entry.key = i_burst_time;
        ctl.new_entry.id  = i_process_id;
    end

    // Row of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic   occupied;
        logic   prev_keep;
        t_entry prev_entry;
        t_entry next_entry;

        assign occupied = (r_count > CNT_W'(g));

        if (g == 0) begin : g_first
            assign prev_keep  = 1'b1;
            assign prev_entry = ctl.new_entry;
        end else begin : g_mid
            assign prev_keep  = w_keep[g-1];
            assign prev_entry = w_entry[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign next_entry = '0;
        end else begin : g_inner
            assign next_entry = w_entry[g+1];
        end

        sjfq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (occupied),
            .i_prev_keep  (prev_keep),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .o_entry      (w_entry[g]),
            .o_keep       (w_keep[g])
        );
    end

    // Count and status for this word
    always_comb begin
        n_count = r_count;
        status  = ST_DONE;
        if (accept) begin
            if (i_op == OP_INSERT) begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
    end

    assign occ_ext = {{OCC_W{1'b0}}, n_count};

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_occupancy <= occ_ext[OCC_W-1:0];
            if (ctl.pop) begin
                r_popped_id   <= w_entry[0].id;
                r_popped_time <= w_entry[0].key;
            end else begin
                r_popped_id   <= '0;
                r_popped_time <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_popped_id   = r_popped_id;
    assign o_popped_time = r_popped_time;
    assign o_status      = r_status;
    assign o_occupancy   = r_occupancy;

`ifndef SYNTHESIS
    logic sorted_ok;

    always_comb begin
        sorted_ok = 1'b1;
        for (int k = 1; k < QUEUE_DEPTH; k++) begin
            if ((r_count > CNT_W'(k)) && (w_entry[k-1].key > w_entry[k].key)) begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_row_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sorted_ok)
        else $error("occupied cells out of order");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.pop |=> (o_out_valid && (o_status == ST_DONE)
                     && (o_popped_time == $past(w_entry[0].key))))
        else $error("pop did not return the head job");
`endif

endmodule

// ----- rtl/sjfq_cell.sv -----
// One slot of the sorted row. Cell 0 holds the shortest job; among equal
// burst times the older job sits nearer cell 0.
module sjfq_cell (
    input  logic               i_clk,
    input  sjfq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_prev_keep,
    input  sjfq_pkg::t_entry   i_prev_entry,
    input  sjfq_pkg::t_entry   i_next_entry,
    output sjfq_pkg::t_entry   o_entry,
    output logic               o_keep
);
    import sjfq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Stay put when this cell is occupied and its job is no longer than the incoming one
    assign o_keep  = i_occupied && (r_entry.key <= i_ctl.new_entry.key);
    assign o_entry = r_entry;

    // Choose hold, load new word, take from lower neighbour or from upper one
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_entry = i_ctl.new_entry;
                end else begin
                    n_entry = i_prev_entry;
                end
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
